// File: rtl/blfm_pkg.sv
`timescale 1ns / 1ps

package blfm_pkg;

   localparam int PCT_BITS      = 7;
   localparam int LEVEL_BITS    = 2;
   localparam int HOLD_BITS     = 8;
   localparam int FAN_HOLD_BITS = 10;
   localparam int TEMP_BITS     = 16;
   localparam int CSR_ADDR_BITS = 5;
   localparam int CSR_DATA_BITS = 32;
   localparam int RSP_DATA_BITS = 16;

   localparam logic [PCT_BITS-1:0] PCT_FULL = 7'd100;

   localparam logic [LEVEL_BITS-1:0] LEVEL_NORMAL   = 2'd0;
   localparam logic [LEVEL_BITS-1:0] LEVEL_LOW      = 2'd1;
   localparam logic [LEVEL_BITS-1:0] LEVEL_CRITICAL = 2'd2;
   localparam logic [LEVEL_BITS-1:0] LEVEL_UNUSED   = 2'd3;

   localparam logic [2:0] REG_LOW_PERCENT      = 3'd0;
   localparam logic [2:0] REG_CRITICAL_PERCENT = 3'd1;
   localparam logic [2:0] REG_LEVEL_HOLD       = 3'd2;
   localparam logic [2:0] REG_FAN_THRESHOLD    = 3'd3;
   localparam logic [2:0] REG_FAN_HOLD         = 3'd4;

   localparam logic [PCT_BITS-1:0]      RST_LOW_PERCENT      = 7'd30;
   localparam logic [PCT_BITS-1:0]      RST_CRITICAL_PERCENT = 7'd20;
   localparam logic [HOLD_BITS-1:0]     RST_LEVEL_HOLD       = 8'd128;
   localparam logic [TEMP_BITS-1:0]     RST_FAN_THRESHOLD    = 16'd3000;
   localparam logic [FAN_HOLD_BITS-1:0] RST_FAN_HOLD         = 10'd600;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DIVIDE,
      ST_UPDATE
   } seq_state_type;

endpackage

// File: rtl/battery_level_and_fan_monitor.sv
`timescale 1ns / 1ps

// Channel   Direction  Transfer when              Payload
// req_      in         req_tvalid & req_tready    tdata: remaining, total, temperature
// rsp_      out        rsp_tvalid & rsp_tready    tdata: percent, level, fan_on
// csr_      in         psel & penable & pwrite    5 registers at 4*i
//
// When the divider runs, an item passes through accept, 7 quotient steps in the
// shared compare/subtract unit, result and update; when total is zero or not above
// remaining, the divider skips the quotient steps. req_tready is high only while the sequencer is idle.
// A result waits in the output register; a stalled rsp_ holds the sequencer in update.
// Synchronous reset restores register defaults and clears level and fan state.

module battery_level_and_fan_monitor #(
   parameter int CAPACITY_BITS = 16
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   // [C-1:0] remaining_capacity, [2C-1:C] total_capacity, [2C+15:2C] temperature
   input  logic [((2*CAPACITY_BITS+16+7)/8)*8-1:0] req_tdata,
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   // [6:0] charge_percent, [8:7] battery_level, [9] fan_on
   output logic [blfm_pkg::RSP_DATA_BITS-1:0]   rsp_tdata,
   input  logic                                 csr_psel,
   input  logic                                 csr_penable,
   input  logic                                 csr_pwrite,
   input  logic [blfm_pkg::CSR_ADDR_BITS-1:0]   csr_paddr,
   input  logic [blfm_pkg::CSR_DATA_BITS-1:0]   csr_pwdata,
   output logic [blfm_pkg::CSR_DATA_BITS-1:0]   csr_prdata,
   output logic                                 csr_pready
);

   localparam int C = CAPACITY_BITS;

   logic [blfm_pkg::PCT_BITS-1:0]      low_pct_ff;
   logic [blfm_pkg::PCT_BITS-1:0]      crit_pct_ff;
   logic [blfm_pkg::HOLD_BITS-1:0]     level_hold_ff;
   logic [blfm_pkg::TEMP_BITS-1:0]     fan_thresh_ff;
   logic [blfm_pkg::FAN_HOLD_BITS-1:0] fan_hold_ff;

   blfm_pkg::seq_state_type            state_ff, state_in;
   logic [blfm_pkg::LEVEL_BITS-1:0]    level_ff, level_in;
   logic [blfm_pkg::HOLD_BITS-1:0]     level_cnt_ff, level_cnt_in;
   logic                               fan_ff, fan_in;
   logic [blfm_pkg::FAN_HOLD_BITS-1:0] fan_cnt_ff, fan_cnt_in;
   logic                               rsp_valid_ff, rsp_valid_in;
   logic [blfm_pkg::PCT_BITS-1:0]      rsp_pct_ff, rsp_pct_in;
   logic [blfm_pkg::PCT_BITS-1:0]      pct_ff, pct_in;
   logic [blfm_pkg::TEMP_BITS-1:0]     temp_ff, temp_in;

   logic                               div_start;
   logic                               div_done;
   logic [blfm_pkg::PCT_BITS-1:0]      div_quot;

   logic                               csr_write;
   logic                               out_free;
   logic [blfm_pkg::HOLD_BITS-1:0]     level_inc;
   logic                               level_reach;
   logic                               level_count_en;
   logic [blfm_pkg::LEVEL_BITS-1:0]    level_target;
   logic                               fan_toward;

   blfm_div #(
      .CAPACITY_BITS (CAPACITY_BITS)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (req_tdata[C-1:0]),
      .divisor  (req_tdata[2*C-1:C]),
      .done     (div_done),
      .quotient (div_quot)
   );

   // Configuration
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel & csr_penable & csr_pwrite & csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         low_pct_ff    <= blfm_pkg::RST_LOW_PERCENT;
         crit_pct_ff   <= blfm_pkg::RST_CRITICAL_PERCENT;
         level_hold_ff <= blfm_pkg::RST_LEVEL_HOLD;
         fan_thresh_ff <= blfm_pkg::RST_FAN_THRESHOLD;
         fan_hold_ff   <= blfm_pkg::RST_FAN_HOLD;
      end else if (csr_write) begin
         case (csr_paddr[4:2])
            blfm_pkg::REG_LOW_PERCENT:      low_pct_ff    <= csr_pwdata[blfm_pkg::PCT_BITS-1:0];
            blfm_pkg::REG_CRITICAL_PERCENT: crit_pct_ff   <= csr_pwdata[blfm_pkg::PCT_BITS-1:0];
            blfm_pkg::REG_LEVEL_HOLD:       level_hold_ff <= csr_pwdata[blfm_pkg::HOLD_BITS-1:0];
            blfm_pkg::REG_FAN_THRESHOLD:    fan_thresh_ff <= csr_pwdata[blfm_pkg::TEMP_BITS-1:0];
            blfm_pkg::REG_FAN_HOLD:         fan_hold_ff   <= csr_pwdata[blfm_pkg::FAN_HOLD_BITS-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_paddr[4:2])
         blfm_pkg::REG_LOW_PERCENT:      csr_prdata = blfm_pkg::CSR_DATA_BITS'(low_pct_ff);
         blfm_pkg::REG_CRITICAL_PERCENT: csr_prdata = blfm_pkg::CSR_DATA_BITS'(crit_pct_ff);
         blfm_pkg::REG_LEVEL_HOLD:       csr_prdata = blfm_pkg::CSR_DATA_BITS'(level_hold_ff);
         blfm_pkg::REG_FAN_THRESHOLD:    csr_prdata = blfm_pkg::CSR_DATA_BITS'(fan_thresh_ff);
         blfm_pkg::REG_FAN_HOLD:         csr_prdata = blfm_pkg::CSR_DATA_BITS'(fan_hold_ff);
         default:                        csr_prdata = '0;
      endcase
   end

   // Level and fan decisions for the update step
   assign out_free    = !rsp_valid_ff || rsp_tready;
   assign level_inc   = level_cnt_ff + 1'b1;
   assign level_reach = level_inc >= level_hold_ff;
   assign fan_toward  = fan_ff ? (temp_ff < fan_thresh_ff) : (temp_ff >= fan_thresh_ff);

   always_comb begin
      level_count_en = 1'b0;
      level_target   = blfm_pkg::LEVEL_NORMAL;
      case (level_ff)
         blfm_pkg::LEVEL_NORMAL: begin
            level_count_en = pct_ff < low_pct_ff;
            level_target   = blfm_pkg::LEVEL_LOW;
         end
         blfm_pkg::LEVEL_LOW: begin
            if (pct_ff >= low_pct_ff) begin
               level_count_en = 1'b1;
               level_target   = blfm_pkg::LEVEL_NORMAL;
            end else if (pct_ff < crit_pct_ff) begin
               level_count_en = 1'b1;
               level_target   = blfm_pkg::LEVEL_CRITICAL;
            end
         end
         blfm_pkg::LEVEL_CRITICAL: begin
            level_count_en = pct_ff >= crit_pct_ff;
            level_target   = blfm_pkg::LEVEL_LOW;
         end
         default: ;
      endcase
   end

   // Sequencer
   always_comb begin
      state_in     = state_ff;
      level_in     = level_ff;
      level_cnt_in = level_cnt_ff;
      fan_in       = fan_ff;
      fan_cnt_in   = fan_cnt_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_pct_in   = rsp_pct_ff;
      pct_in       = pct_ff;
      temp_in      = temp_ff;
      req_tready   = 1'b0;
      div_start    = 1'b0;
      case (state_ff)
         blfm_pkg::ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               div_start = 1'b1;
               temp_in   = req_tdata[2*C+blfm_pkg::TEMP_BITS-1:2*C];
               state_in  = blfm_pkg::ST_DIVIDE;
            end
         end
         blfm_pkg::ST_DIVIDE: begin
            if (div_done) begin
               pct_in   = div_quot;
               state_in = blfm_pkg::ST_UPDATE;
            end
         end
         blfm_pkg::ST_UPDATE: begin
            if (out_free) begin
               if (level_ff == blfm_pkg::LEVEL_UNUSED) begin
                  level_in     = blfm_pkg::LEVEL_NORMAL;
                  level_cnt_in = '0;
               end else if (!level_count_en) begin
                  level_cnt_in = '0;
               end else if (level_reach) begin
                  level_cnt_in = '0;
                  level_in     = level_target;
               end else begin
                  level_cnt_in = level_inc;
               end
               if (!fan_toward) begin
                  fan_cnt_in = '0;
               end else if (fan_cnt_ff < fan_hold_ff) begin
                  fan_cnt_in = fan_cnt_ff + 1'b1;
               end else begin
                  fan_in = !fan_ff;
               end
               rsp_valid_in = 1'b1;
               rsp_pct_in   = pct_ff;
               state_in     = blfm_pkg::ST_IDLE;
            end
         end
         default: state_in = blfm_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= blfm_pkg::ST_IDLE;
         level_ff     <= blfm_pkg::LEVEL_NORMAL;
         level_cnt_ff <= '0;
         fan_ff       <= 1'b0;
         fan_cnt_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         level_ff     <= level_in;
         level_cnt_ff <= level_cnt_in;
         fan_ff       <= fan_in;
         fan_cnt_ff   <= fan_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_pct_ff <= rsp_pct_in;
      pct_ff     <= pct_in;
      temp_ff    <= temp_in;
   end

   // level and fan change together with the result, so their registers and the result register form the payload
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = blfm_pkg::RSP_DATA_BITS'({fan_ff, level_ff, rsp_pct_ff});

   a_pct_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_pct_ff <= blfm_pkg::PCT_FULL)
      else $error("charge percent above full scale");

   a_done_in_divide: assert property (@(posedge clock) disable iff (reset)
      div_done |-> state_ff == blfm_pkg::ST_DIVIDE)
      else $error("divider result outside divide step");

   a_accept_starts: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> state_ff == blfm_pkg::ST_DIVIDE)
      else $error("transfer accepted without starting division");

   a_level_neighbour: assert property (@(posedge clock) disable iff (reset)
      level_ff == blfm_pkg::LEVEL_CRITICAL |-> $past(level_ff) != blfm_pkg::LEVEL_NORMAL)
      else $error("level skipped from normal to critical");

   a_state_only_on_commit: assert property (@(posedge clock) disable iff (reset)
      state_ff != blfm_pkg::ST_UPDATE |=> $stable(fan_ff))
      else $error("fan changed outside update");

endmodule

// File: rtl/blfm_div.sv
`timescale 1ns / 1ps

module blfm_div #(
   parameter int CAPACITY_BITS = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [CAPACITY_BITS-1:0]      dividend,
   input  logic [CAPACITY_BITS-1:0]      divisor,
   output logic                          done,
   output logic [blfm_pkg::PCT_BITS-1:0] quotient
);

   localparam int WIDE_BITS = CAPACITY_BITS + blfm_pkg::PCT_BITS;
   localparam int STEP_BITS = $clog2(blfm_pkg::PCT_BITS);
   localparam logic [STEP_BITS-1:0] STEP_LAST = STEP_BITS'(blfm_pkg::PCT_BITS - 1);

   logic [WIDE_BITS-1:0]           part_ff, part_in;
   logic [CAPACITY_BITS-1:0]       divisor_ff, divisor_in;
   logic [STEP_BITS-1:0]           step_ff, step_in;
   logic [blfm_pkg::PCT_BITS-1:0]  quot_ff, quot_in;
   logic                           busy_ff, busy_in;
   logic                           done_ff, done_in;

   logic [WIDE_BITS-1:0] wide_rem;
   logic [WIDE_BITS-1:0] scaled;
   logic [WIDE_BITS-1:0] trial;
   logic                 fits;

   // x100 as 64 + 32 + 4; only used once remaining < total, so quotient < 100
   assign wide_rem = WIDE_BITS'(dividend);
   assign scaled   = (wide_rem << 6) + (wide_rem << 5) + (wide_rem << 2);
   assign trial    = WIDE_BITS'(divisor_ff) << step_ff;
   assign fits     = part_ff >= trial;

   always_comb begin
      part_in    = part_ff;
      divisor_in = divisor_ff;
      step_in    = step_ff;
      quot_in    = quot_ff;
      busy_in    = busy_ff;
      done_in    = 1'b0;
      if (start) begin
         if (divisor == '0) begin
            quot_in = '0;
            done_in = 1'b1;
         end else if (dividend >= divisor) begin
            quot_in = blfm_pkg::PCT_FULL;
            done_in = 1'b1;
         end else begin
            part_in    = scaled;
            divisor_in = divisor;
            quot_in    = '0;
            step_in    = STEP_LAST;
            busy_in    = 1'b1;
         end
      end else if (busy_ff) begin
         if (fits) begin
            part_in = part_ff - trial;
         end
         quot_in = {quot_ff[blfm_pkg::PCT_BITS-2:0], fits};
         if (step_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end else begin
            step_in = step_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      part_ff    <= part_in;
      divisor_ff <= divisor_in;
      step_ff    <= step_in;
      quot_ff    <= quot_in;
   end

   assign done     = done_ff;
   assign quotient = quot_ff;

endmodule

// File: tb/sv/battery_level_and_fan_monitor_tb.sv
`timescale 1ns / 1ps

module battery_level_and_fan_monitor_tb;

   localparam int          CLK_HALF     = 6;
   localparam int          SETTLE       = 6;
   localparam int          CYCLE_LIMIT  = 200000;
   localparam int          PHASES       = 8;
   localparam int          PHASE_ITEMS  = 80;
   localparam int          REG_COUNT    = 5;
   localparam logic [2:0]  REG_UNMAPPED = 3'd5;

   typedef struct {
      logic [blfm_pkg::PCT_BITS-1:0]   charge;
      logic [blfm_pkg::LEVEL_BITS-1:0] level;
      logic                            fan_on;
   } reading_type;

   typedef struct {
      bit          is_write;
      logic [2:0]  reg_idx;
      logic [31:0] value;
      logic [15:0] remaining;
      logic [15:0] total;
      logic [15:0] temperature;
      bit          typed;
      reading_type outcome;
   } plan_row_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   // [15:0] remaining_capacity, [31:16] total_capacity, [47:32] temperature
   logic [47:0] req_tdata = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   // [6:0] charge_percent, [8:7] battery_level, [9] fan_on
   logic [blfm_pkg::RSP_DATA_BITS-1:0] rsp_tdata;
   logic        csr_psel = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite = 1'b0;
   logic [blfm_pkg::CSR_ADDR_BITS-1:0] csr_paddr = '0;
   logic [blfm_pkg::CSR_DATA_BITS-1:0] csr_pwdata = '0;
   logic [blfm_pkg::CSR_DATA_BITS-1:0] csr_prdata;
   logic        csr_pready;

   // register mirror
   logic [blfm_pkg::PCT_BITS-1:0]      cfg_low        = blfm_pkg::RST_LOW_PERCENT;
   logic [blfm_pkg::PCT_BITS-1:0]      cfg_critical   = blfm_pkg::RST_CRITICAL_PERCENT;
   logic [blfm_pkg::HOLD_BITS-1:0]     cfg_level_hold = blfm_pkg::RST_LEVEL_HOLD;
   logic [blfm_pkg::TEMP_BITS-1:0]     cfg_fan_thr    = blfm_pkg::RST_FAN_THRESHOLD;
   logic [blfm_pkg::FAN_HOLD_BITS-1:0] cfg_fan_hold   = blfm_pkg::RST_FAN_HOLD;

   // mirrored block state
   logic [blfm_pkg::LEVEL_BITS-1:0]    batt_level = blfm_pkg::LEVEL_NORMAL;
   logic [blfm_pkg::HOLD_BITS-1:0]     batt_count = '0;
   logic                               fan_running = 1'b0;
   logic [blfm_pkg::FAN_HOLD_BITS-1:0] fan_count = '0;

   reading_type  pending_readings[$];
   plan_row_type plan[$];

   int  failures = 0;
   int  periods_sent = 0;
   int  readings_checked = 0;
   int  settings_applied = 0;
   int  cycles = 0;
   int  stall_left = 0;
   bit  allow_gaps = 1'b1;

   battery_level_and_fan_monitor DUT (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   initial begin
      forever #CLK_HALF clock = ~clock;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles, %0d readings outstanding", cycles,
                  pending_readings.size());
         $display("Simulation FAILED");
         $finish;
      end
   end

   function automatic void advance_level(input logic [blfm_pkg::LEVEL_BITS-1:0] next_level);
      batt_count = batt_count + 1'b1;
      if (batt_count >= cfg_level_hold) begin
         batt_count = '0;
         batt_level = next_level;
      end
   endfunction

   function automatic reading_type evaluate_period(input logic [15:0] rem,
                                                   input logic [15:0] tot,
                                                   input logic [15:0] temp);
      reading_type r;
      logic [31:0] pct;
      bit          toward;
      if (tot == 16'd0)
         pct = '0;
      else
         pct = ({16'd0, rem} * 32'd100) / {16'd0, tot};
      if (pct > 32'd100)
         pct = 32'd100;

      case (batt_level)
         blfm_pkg::LEVEL_NORMAL: begin
            if (pct < cfg_low) advance_level(blfm_pkg::LEVEL_LOW);
            else batt_count = '0;
         end
         blfm_pkg::LEVEL_LOW: begin
            if (pct >= cfg_low) advance_level(blfm_pkg::LEVEL_NORMAL);
            else if (pct < cfg_critical) advance_level(blfm_pkg::LEVEL_CRITICAL);
            else batt_count = '0;
         end
         blfm_pkg::LEVEL_CRITICAL: begin
            if (pct >= cfg_critical) advance_level(blfm_pkg::LEVEL_LOW);
            else batt_count = '0;
         end
         default: begin
            batt_level = blfm_pkg::LEVEL_NORMAL;
            batt_count = '0;
         end
      endcase

      toward = fan_running ? (temp < cfg_fan_thr) : (temp >= cfg_fan_thr);
      if (toward) begin
         if (fan_count < cfg_fan_hold) fan_count = fan_count + 1'b1;
         else fan_running = ~fan_running;
      end else begin
         fan_count = '0;
      end

      r.charge = pct[blfm_pkg::PCT_BITS-1:0];
      r.level  = batt_level;
      r.fan_on = fan_running;
      return r;
   endfunction

   function automatic plan_row_type period_row(input logic [15:0] rem, input logic [15:0] tot,
                                               input logic [15:0] temp);
      plan_row_type p;
      p = '{default: '0};
      p.remaining   = rem;
      p.total       = tot;
      p.temperature = temp;
      return p;
   endfunction

   function automatic plan_row_type typed_row(input logic [15:0] rem, input logic [15:0] tot,
                                              input logic [15:0] temp, input logic [6:0] pct,
                                              input logic [1:0] lvl, input logic fan);
      plan_row_type p;
      p = period_row(rem, tot, temp);
      p.typed          = 1'b1;
      p.outcome.charge = pct;
      p.outcome.level  = lvl;
      p.outcome.fan_on = fan;
      return p;
   endfunction

   function automatic plan_row_type write_row(input logic [2:0] idx, input logic [31:0] val);
      plan_row_type p;
      p = '{default: '0};
      p.is_write = 1'b1;
      p.reg_idx  = idx;
      p.value    = val;
      return p;
   endfunction

   // called at a falling edge, returns at a falling edge
   task automatic send_period(input logic [15:0] rem, input logic [15:0] tot,
                              input logic [15:0] temp, input bit typed,
                              input reading_type typed_val);
      int          gap;
      reading_type predicted;
      gap = (allow_gaps && $urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 0;
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {temp, tot, rem};
      do @(posedge clock); while (!req_tready);
      predicted = evaluate_period(rem, tot, temp);
      pending_readings.push_back(typed ? typed_val : predicted);
      periods_sent++;
      @(negedge clock);
   endtask

   // drains the block so registers can be touched
   task automatic quiesce();
      req_tvalid <= 1'b0;
      while (pending_readings.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic write_register(input logic [2:0] idx, input logic [31:0] val);
      csr_psel    <= 1'b1;
      csr_pwrite  <= 1'b1;
      csr_penable <= 1'b0;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= val;
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      case (idx)
         blfm_pkg::REG_LOW_PERCENT:      cfg_low        = val[blfm_pkg::PCT_BITS-1:0];
         blfm_pkg::REG_CRITICAL_PERCENT: cfg_critical   = val[blfm_pkg::PCT_BITS-1:0];
         blfm_pkg::REG_LEVEL_HOLD:       cfg_level_hold = val[blfm_pkg::HOLD_BITS-1:0];
         blfm_pkg::REG_FAN_THRESHOLD:    cfg_fan_thr    = val[blfm_pkg::TEMP_BITS-1:0];
         blfm_pkg::REG_FAN_HOLD:         cfg_fan_hold   = val[blfm_pkg::FAN_HOLD_BITS-1:0];
         default: ;
      endcase
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(negedge clock);
   endtask

   task automatic check_registers();
      logic [2:0]  idx;
      logic [31:0] want;
      for (int i = 0; i < REG_COUNT; i++) begin
         idx = i[2:0];
         case (idx)
            blfm_pkg::REG_LOW_PERCENT:      want = 32'(cfg_low);
            blfm_pkg::REG_CRITICAL_PERCENT: want = 32'(cfg_critical);
            blfm_pkg::REG_LEVEL_HOLD:       want = 32'(cfg_level_hold);
            blfm_pkg::REG_FAN_THRESHOLD:    want = 32'(cfg_fan_thr);
            default:                        want = 32'(cfg_fan_hold);
         endcase
         csr_psel    <= 1'b1;
         csr_pwrite  <= 1'b0;
         csr_penable <= 1'b0;
         csr_paddr   <= {idx, 2'b00};
         @(negedge clock);
         csr_penable <= 1'b1;
         do @(posedge clock); while (!csr_pready);
         if (csr_prdata !== want) begin
            $error("register %0d: expected %0d, got %0d", idx, want, csr_prdata);
            failures++;
         end
         @(negedge clock);
         csr_psel    <= 1'b0;
         csr_penable <= 1'b0;
         @(negedge clock);
      end
   endtask

   always @(negedge clock) begin
      if (stall_left > 0) begin
         rsp_tready <= 1'b0;
         stall_left <= stall_left - 1;
      end else if (allow_gaps && $urandom_range(0, 4) == 0) begin
         rsp_tready <= 1'b0;
         stall_left <= $urandom_range(0, 2);
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      reading_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_readings.size() == 0) begin
            $error("reading with nothing outstanding: tdata %h", rsp_tdata);
            failures++;
         end else begin
            want = pending_readings.pop_front();
            readings_checked++;
            if (rsp_tdata[6:0] !== want.charge) begin
               $error("charge_percent: expected %0d, got %0d", want.charge, rsp_tdata[6:0]);
               failures++;
            end
            if (rsp_tdata[8:7] !== want.level) begin
               $error("battery_level: expected %0d, got %0d", want.level, rsp_tdata[8:7]);
               failures++;
            end
            if (rsp_tdata[9] !== want.fan_on) begin
               $error("fan_on: expected %0d, got %0d", want.fan_on, rsp_tdata[9]);
               failures++;
            end
         end
      end
   end

   initial begin
      reading_type none;
      int          band, hot, lvl_run, fan_run, run_cap;
      int unsigned lo, hi, p, t, r, thr;
      logic [15:0] rem, tot, temp;

      none = '{default: '0};
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // defaults: level and fan holds far too long to move anything
      plan.push_back(typed_row(16'd0,     16'd0,     16'd0,     7'd0,
                               blfm_pkg::LEVEL_NORMAL, 1'b0));
      plan.push_back(typed_row(16'hFFFF,  16'hFFFF,  16'hFFFF,  7'd100,
                               blfm_pkg::LEVEL_NORMAL, 1'b0));
      plan.push_back(typed_row(16'hFFFF,  16'd1,     16'd0,     blfm_pkg::PCT_FULL,
                               blfm_pkg::LEVEL_NORMAL, 1'b0));
      plan.push_back(typed_row(16'd1,     16'hFFFF,  16'd3000,  7'd0,
                               blfm_pkg::LEVEL_NORMAL, 1'b0));
      plan.push_back(typed_row(16'h7FFF,  16'hFFFF,  16'd2999,  7'd49,
                               blfm_pkg::LEVEL_NORMAL, 1'b0));
      plan.push_back(typed_row(16'hFFFF,  16'd0,     16'hFFFF,  7'd0,
                               blfm_pkg::LEVEL_NORMAL, 1'b0));
      plan.push_back(typed_row(16'd50,    16'd100,   16'h5555,  7'd50,
                               blfm_pkg::LEVEL_NORMAL, 1'b0));
      plan.push_back(typed_row(16'd29,    16'd100,   16'hAAAA,  7'd29,
                               blfm_pkg::LEVEL_NORMAL, 1'b0));
      plan.push_back(typed_row(16'd30,    16'd100,   16'd0,     7'd30,
                               blfm_pkg::LEVEL_NORMAL, 1'b0));
      // zero holds, thresholds beyond 100 percent, unmapped register
      plan.push_back(write_row(blfm_pkg::REG_LEVEL_HOLD, 32'd0));
      plan.push_back(write_row(blfm_pkg::REG_FAN_HOLD, 32'd0));
      plan.push_back(write_row(REG_UNMAPPED, 32'hFFFF_FFFF));
      plan.push_back(write_row(blfm_pkg::REG_LOW_PERCENT, 32'd127));
      plan.push_back(period_row(16'd100, 16'd100, 16'd5000));
      plan.push_back(period_row(16'd0, 16'd100, 16'd0));
      plan.push_back(write_row(blfm_pkg::REG_CRITICAL_PERCENT, 32'd127));
      plan.push_back(period_row(16'd0, 16'd100, 16'd100));
      plan.push_back(write_row(blfm_pkg::REG_FAN_THRESHOLD, 32'd0));
      plan.push_back(period_row(16'hFFFF, 16'd1000, 16'd0));
      plan.push_back(write_row(blfm_pkg::REG_FAN_THRESHOLD, 32'hFFFF));
      plan.push_back(write_row(blfm_pkg::REG_CRITICAL_PERCENT, 32'd0));
      plan.push_back(period_row(16'd7, 16'd7, 16'hFFFE));
      plan.push_back(period_row(16'd1, 16'd3, 16'hFFFF));
      plan.push_back(period_row(16'd2, 16'd3, 16'hFFFF));

      foreach (plan[i]) begin
         if (plan[i].is_write) begin
            quiesce();
            write_register(plan[i].reg_idx, plan[i].value);
            settings_applied++;
         end else begin
            send_period(plan[i].remaining, plan[i].total, plan[i].temperature,
                        plan[i].typed, plan[i].outcome);
         end
      end

      for (int ph = 0; ph < PHASES; ph++) begin
         quiesce();
         if (ph == PHASES - 1)
            allow_gaps = 1'b0;
         if (ph == 0) begin
            // upper bits beyond each field are dropped
            for (int i = 0; i < REG_COUNT; i++)
               write_register(i[2:0], 32'hFFFF_FFFF);
         end else if (ph == 1) begin
            for (int i = 0; i < REG_COUNT; i++)
               write_register(i[2:0], 32'd0);
         end else begin
            lo = $urandom_range(5, 90);
            if ($urandom_range(0, 5) == 0) lo = $urandom_range(0, 127);
            write_register(blfm_pkg::REG_LOW_PERCENT, lo);
            write_register(blfm_pkg::REG_CRITICAL_PERCENT, $urandom_range(0, lo));
            write_register(blfm_pkg::REG_LEVEL_HOLD, $urandom_range(1, 6));
            write_register(blfm_pkg::REG_FAN_THRESHOLD, $urandom_range(0, 65535));
            write_register(blfm_pkg::REG_FAN_HOLD, $urandom_range(0, 8));
         end
         settings_applied++;
         check_registers();

         lvl_run = 0;
         fan_run = 0;
         band = 0;
         hot = 0;
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            if (lvl_run == 0) begin
               band = $urandom_range(0, 2);
               run_cap = (cfg_level_hold + 2 > 40) ? 40 : cfg_level_hold + 2;
               lvl_run = $urandom_range(1, run_cap);
            end
            lvl_run--;
            if (fan_run == 0) begin
               hot = $urandom_range(0, 1);
               run_cap = (cfg_fan_hold + 2 > 40) ? 40 : cfg_fan_hold + 2;
               fan_run = $urandom_range(1, run_cap);
            end
            fan_run--;

            case (band)
               0: begin
                  lo = 0;
                  hi = (cfg_critical == 0) ? 0 : cfg_critical - 1;
               end
               1: begin
                  lo = 32'(cfg_critical);
                  hi = (cfg_low > cfg_critical) ? cfg_low - 1 : cfg_critical;
               end
               default: begin
                  lo = (cfg_low > 100) ? 100 : 32'(cfg_low);
                  hi = 100;
               end
            endcase
            if (lo > 100) lo = 100;
            if (hi > 100) hi = 100;
            p = $urandom_range(hi, lo);
            t = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 200) : $urandom_range(1, 65535);
            r = t * p / 100 + $urandom_range(0, t / 100);
            if (r > 65535) r = 65535;
            rem = r[15:0];
            tot = t[15:0];
            if ($urandom_range(0, 7) == 0) begin
               rem = 16'($urandom);
               tot = ($urandom_range(0, 4) == 0) ? 16'd0 : 16'($urandom);
            end

            thr = 32'(cfg_fan_thr);
            if (hot != 0 || thr == 0)
               temp = 16'($urandom_range(65535, thr));
            else
               temp = 16'($urandom_range(thr - 1, 0));
            if ($urandom_range(0, 7) == 0)
               temp = 16'($urandom);

            send_period(rem, tot, temp, 1'b0, none);
         end
      end

      quiesce();
      $display("%0d periods sent, %0d readings checked", periods_sent, readings_checked);
      $display("%0d register settings, including all-ones and all-zero holds and thresholds",
               settings_applied);
      if (failures == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("%0d mismatches", failures);
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule
